// ----- hw/rtl/isq_pkg.sv -----
// Shared types and constants for the 64-bit table and Newton square root pipeline.
`default_nettype none
package isq_pkg;

  // Field widths.
  localparam int N_W     = 64;
  localparam int ROOT_W  = 32;
  localparam int CHUNK_W = 16;

  // Number of cells in each chain: one per root bit, one per quotient bit.
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS  = 64;

  // Right shifts that follow the interpolation.
  localparam logic [4:0] SH_TOP   = 5'd0;
  localparam logic [4:0] SH_MID   = 5'd8;
  localparam logic [4:0] SH_LOW   = 5'd16;
  localparam int         SMALL_SH = 24;

  // Per-item data that rides along with the table lookup.
  typedef struct packed {
    logic [N_W-1:0]     n;
    logic [CHUNK_W-1:0] md;
    logic [4:0]         sh;
    logic               tiny;
    logic               zero;
  } isq_side_t;

  // One lane of the bitwise root: argument bits still to consume,
  // partial remainder and partial root.
  typedef struct packed {
    logic [CHUNK_W-1:0] arg;
    logic [ROOT_W+1:0]  rem;
    logic [ROOT_W-1:0]  root;
  } isq_sqrt_lane_t;

  // Stage handed from one root cell to the next; two table words per item.
  typedef struct packed {
    logic           vld;
    isq_side_t      side;
    isq_sqrt_lane_t lo;
    isq_sqrt_lane_t hi;
  } isq_sqrt_stage_t;

  // Stage handed from one divider cell to the next.
  typedef struct packed {
    logic           vld;
    logic           bypass;
    logic [N_W-1:0] n;
    logic [N_W-1:0] r;
    logic [N_W-1:0] num;
    logic [N_W-1:0] rem;
    logic [N_W-1:0] quo;
  } isq_div_stage_t;

endpackage
`default_nettype wire

// ----- hw/rtl/isq_sqrt_cell.sv -----
// One cell of the bitwise square root chain that rebuilds two table words.
`default_nettype none
module isq_sqrt_cell (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       en,
  input  isq_pkg::isq_sqrt_stage_t  stg_i,
  output isq_pkg::isq_sqrt_stage_t  stg_o
);

  isq_pkg::isq_sqrt_stage_t stg_r;
  isq_pkg::isq_sqrt_stage_t stg_nxt;

  // One restoring step: bring in two argument bits, try the next root bit.
  function automatic isq_pkg::isq_sqrt_lane_t lane_step(input isq_pkg::isq_sqrt_lane_t l);
    isq_pkg::isq_sqrt_lane_t o;
    logic [isq_pkg::ROOT_W+1:0] cand;
    logic [isq_pkg::ROOT_W+1:0] trial;
    cand  = {l.rem[isq_pkg::ROOT_W-1:0], l.arg[isq_pkg::CHUNK_W-1 -: 2]};
    trial = {l.root, 2'b01};
    o.arg = {l.arg[isq_pkg::CHUNK_W-3:0], 2'b00};
    if (cand >= trial) begin
      o.rem  = cand - trial;
      o.root = {l.root[isq_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = cand;
      o.root = {l.root[isq_pkg::ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Both lanes step together; side data passes unchanged.
  always_comb begin
    stg_nxt      = stg_i;
    stg_nxt.lo   = lane_step(stg_i.lo);
    stg_nxt.hi   = lane_step(stg_i.hi);
  end

  // Valid bit is control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else if (en) begin
      stg_r.vld <= stg_nxt.vld;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r.side <= stg_nxt.side;
      stg_r.lo   <= stg_nxt.lo;
      stg_r.hi   <= stg_nxt.hi;
    end
  end

  assign stg_o = stg_r;

endmodule
`default_nettype wire

// ----- hw/rtl/isq_div_cell.sv -----
// One cell of the restoring divider chain used by the Newton steps.
`default_nettype none
module isq_div_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      en,
  input  isq_pkg::isq_div_stage_t  stg_i,
  output isq_pkg::isq_div_stage_t  stg_o
);

  isq_pkg::isq_div_stage_t stg_r;
  isq_pkg::isq_div_stage_t stg_nxt;
  logic [isq_pkg::N_W:0]   cand;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    stg_nxt     = stg_i;
    cand        = {stg_i.rem, stg_i.num[isq_pkg::N_W-1]};
    stg_nxt.num = {stg_i.num[isq_pkg::N_W-2:0], 1'b0};
    if (cand >= {1'b0, stg_i.r}) begin
      stg_nxt.rem = isq_pkg::N_W'(cand - {1'b0, stg_i.r});
      stg_nxt.quo = {stg_i.quo[isq_pkg::N_W-2:0], 1'b1};
    end else begin
      stg_nxt.rem = cand[isq_pkg::N_W-1:0];
      stg_nxt.quo = {stg_i.quo[isq_pkg::N_W-2:0], 1'b0};
    end
  end

  // Valid bit is control state and is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r.vld <= 1'b0;
    end else if (en) begin
      stg_r.vld <= stg_nxt.vld;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r.bypass <= stg_nxt.bypass;
      stg_r.n      <= stg_nxt.n;
      stg_r.r      <= stg_nxt.r;
      stg_r.num    <= stg_nxt.num;
      stg_r.rem    <= stg_nxt.rem;
      stg_r.quo    <= stg_nxt.quo;
    end
  end

  assign stg_o = stg_r;

endmodule
`default_nettype wire

// ----- hw/rtl/integer_sqrt_64_table_newton.sv -----
// Top level of the pipelined 64-bit approximate square root.
`default_nettype none
// Streams 64-bit unsigned radicands in and 32-bit roots out, one transfer per
// cycle on each side with no gaps between items while the output is not
// stalled. Each root is the floor square root or one off from it. The table
// words are rebuilt on the fly by a chain of 32 bitwise root cells (two words
// per item side by side), followed by one multiply stage, one interpolate
// stage, two chains of 64 divider cells for the Newton steps and their add
// stages. A stall on the output holds the whole pipeline, and it is released
// as soon as the result register is taken.
module integer_sqrt_64_table_newton (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [63:0] radicand
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata   // [31:0] root
);

  localparam int NW = isq_pkg::N_W;
  localparam int RW = isq_pkg::ROOT_W;
  localparam int CW = isq_pkg::CHUNK_W;
  localparam int SC = isq_pkg::SQRT_CELLS;
  localparam int DC = isq_pkg::DIV_CELLS;

  typedef struct packed {
    logic              vld;
    isq_pkg::isq_side_t side;
    logic [RW-1:0]     base;
    logic [RW+CW-1:0]  prod;
  } interp_t;

  logic en;

  isq_pkg::isq_sqrt_stage_t sq [0:SC];
  isq_pkg::isq_sqrt_stage_t dec_nxt;
  isq_pkg::isq_sqrt_stage_t dec_r;

  interp_t                  mul_r;
  interp_t                  mul_nxt;

  isq_pkg::isq_div_stage_t  dv1 [0:DC];
  isq_pkg::isq_div_stage_t  dv2 [0:DC];
  isq_pkg::isq_div_stage_t  est_r;
  isq_pkg::isq_div_stage_t  est_nxt;
  isq_pkg::isq_div_stage_t  nw1_r;
  isq_pkg::isq_div_stage_t  nw1_nxt;

  logic                     out_tvalid_r;
  logic [RW-1:0]            out_tdata_r;
  logic [RW-1:0]            out_tdata_nxt;

  // The whole pipeline moves unless a finished result is still waiting.
  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // Pick the top nonzero chunk, the chunk below it and the final shift.
  always_comb begin
    logic [CW-1:0] hi;
    hi               = '0;
    dec_nxt.vld      = in_tvalid;
    dec_nxt.side.n   = in_tdata;
    dec_nxt.side.md  = '0;
    dec_nxt.side.sh  = isq_pkg::SH_TOP;
    dec_nxt.side.tiny  = 1'b0;
    dec_nxt.side.zero  = 1'b0;
    if (in_tdata[63:48] != '0) begin
      hi              = in_tdata[63:48];
      dec_nxt.side.md = in_tdata[47:32];
    end else if (in_tdata[47:32] != '0) begin
      hi              = in_tdata[47:32];
      dec_nxt.side.md = in_tdata[31:16];
      dec_nxt.side.sh = isq_pkg::SH_MID;
    end else if (in_tdata[31:16] != '0) begin
      hi              = in_tdata[31:16];
      dec_nxt.side.md = in_tdata[15:0];
      dec_nxt.side.sh = isq_pkg::SH_LOW;
    end else begin
      // Small radicand: only the word at address n-1 is needed.
      hi                 = in_tdata[15:0];
      dec_nxt.side.tiny  = 1'b1;
      dec_nxt.side.zero  = (in_tdata[15:0] == '0);
    end
    // Word at address a is the root of (a+1) in the top chunk.
    dec_nxt.lo.arg  = hi;
    dec_nxt.lo.rem  = '0;
    dec_nxt.lo.root = '0;
    dec_nxt.hi.arg  = hi + CW'(1);
    dec_nxt.hi.rem  = '0;
    dec_nxt.hi.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_r.vld <= 1'b0;
    end else if (en) begin
      dec_r.vld <= dec_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec_r.side <= dec_nxt.side;
      dec_r.lo   <= dec_nxt.lo;
      dec_r.hi   <= dec_nxt.hi;
    end
  end

  // Chain of root cells that rebuild the two table words.
  assign sq[0] = dec_r;

  for (genvar i = 0; i < SC; i++) begin : g_sqrt
    isq_sqrt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (sq[i]),
      .stg_o (sq[i+1])
    );
  end

  // Difference between the words times the fraction chunk.
  always_comb begin
    logic [RW-1:0] diff;
    diff          = sq[SC].hi.root - sq[SC].lo.root;
    mul_nxt.vld   = sq[SC].vld;
    mul_nxt.side  = sq[SC].side;
    mul_nxt.base  = sq[SC].lo.root;
    mul_nxt.prod  = (RW+CW)'(diff) * (RW+CW)'(sq[SC].side.md);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_r.vld <= 1'b0;
    end else if (en) begin
      mul_r.vld <= mul_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_r.side <= mul_nxt.side;
      mul_r.base <= mul_nxt.base;
      mul_r.prod <= mul_nxt.prod;
    end
  end

  // Interpolated estimate, shifted down; small radicands finish here.
  always_comb begin
    logic [RW:0] sum;
    sum            = {1'b0, mul_r.base} + {1'b0, mul_r.prod[RW+CW-1:CW]};
    est_nxt.vld    = mul_r.vld;
    est_nxt.bypass = mul_r.side.tiny;
    est_nxt.n      = mul_r.side.n;
    est_nxt.num    = mul_r.side.n;
    est_nxt.rem    = '0;
    est_nxt.quo    = '0;
    if (mul_r.side.zero) begin
      est_nxt.r = '0;
    end else if (mul_r.side.tiny) begin
      est_nxt.r = NW'(mul_r.base >> isq_pkg::SMALL_SH);
    end else begin
      est_nxt.r = NW'(sum >> mul_r.side.sh);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      est_r.vld <= 1'b0;
    end else if (en) begin
      est_r.vld <= est_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      est_r.bypass <= est_nxt.bypass;
      est_r.n      <= est_nxt.n;
      est_r.r      <= est_nxt.r;
      est_r.num    <= est_nxt.num;
      est_r.rem    <= est_nxt.rem;
      est_r.quo    <= est_nxt.quo;
    end
  end

  // First Newton division n / r.
  assign dv1[0] = est_r;

  for (genvar i = 0; i < DC; i++) begin : g_div1
    isq_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (dv1[i]),
      .stg_o (dv1[i+1])
    );
  end

  // First Newton update, and setup of the second division.
  always_comb begin
    logic [NW-1:0] q;
    q              = (dv1[DC].r == '0) ? '0 : dv1[DC].quo;
    nw1_nxt.vld    = dv1[DC].vld;
    nw1_nxt.bypass = dv1[DC].bypass;
    nw1_nxt.n      = dv1[DC].n;
    nw1_nxt.num    = dv1[DC].n;
    nw1_nxt.rem    = '0;
    nw1_nxt.quo    = '0;
    if (dv1[DC].bypass) begin
      nw1_nxt.r = dv1[DC].r;
    end else begin
      nw1_nxt.r = (dv1[DC].r + q) >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nw1_r.vld <= 1'b0;
    end else if (en) begin
      nw1_r.vld <= nw1_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nw1_r.bypass <= nw1_nxt.bypass;
      nw1_r.n      <= nw1_nxt.n;
      nw1_r.r      <= nw1_nxt.r;
      nw1_r.num    <= nw1_nxt.num;
      nw1_r.rem    <= nw1_nxt.rem;
      nw1_r.quo    <= nw1_nxt.quo;
    end
  end

  // Second Newton division.
  assign dv2[0] = nw1_r;

  for (genvar i = 0; i < DC; i++) begin : g_div2
    isq_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .stg_i (dv2[i]),
      .stg_o (dv2[i+1])
    );
  end

  // Second Newton update into the result register.
  always_comb begin
    logic [NW-1:0] q;
    logic [NW-1:0] r2;
    q  = (dv2[DC].r == '0) ? '0 : dv2[DC].quo;
    r2 = (dv2[DC].r + q) >> 1;
    if (dv2[DC].bypass) begin
      out_tdata_nxt = dv2[DC].r[RW-1:0];
    end else begin
      out_tdata_nxt = r2[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv2[DC].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef SYNTHESIS
  // The interpolated estimate is never below 256 for large radicands.
  a_est_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (est_r.vld && !est_r.bypass) |-> (est_r.r >= NW'(256)))
    else $error("estimate below 256");

  // The first division leaves a remainder below the divisor.
  a_div1_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv1[DC].vld && dv1[DC].r != '0) |-> (dv1[DC].rem < dv1[DC].r))
    else $error("first division remainder out of range");

  // The second division leaves a remainder below the divisor.
  a_div2_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv2[DC].vld && dv2[DC].r != '0) |-> (dv2[DC].rem < dv2[DC].r))
    else $error("second division remainder out of range");

  // A stall freezes the valid bits of the decode, multiply, estimate and first update registers.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(dec_r.vld) && $stable(mul_r.vld) && $stable(est_r.vld)
             && $stable(nw1_r.vld)))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire
